/* rtl/core/chs_pkg.sv */
`default_nettype none
package chs_pkg;

  localparam int TABLE_SIZE_DEF = 256;

  // load limit: count * LOAD_DEN must stay within TABLE_SIZE * LOAD_NUM
  localparam int LOAD_NUM = 3;
  localparam int LOAD_DEN = 4;

  localparam int KIND_W   = 2;
  localparam int TYPE_W   = 4;
  localparam int VALUE_W  = 64;
  localparam int HASH_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_RMISS    = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_FULL     = 3'd6,
    ST_RSVD     = 3'd7
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/chs_ram.sv */
`default_nettype none
module chs_ram
  import chs_pkg::*;
#(
  parameter int DEPTH = TABLE_SIZE_DEF,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     ren,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/coalesced_hash_set_engine.sv */
// A find walks the chain from the home slot; a remove walks it too and then rewrites the links;
// insert places the key in a free home, links it into the chain from a free slot, or rehomes
// a foreign chain's entry, probing the descending free cursor and walking that chain. A rebuild
// (cursor exhausted) copies the table to scratch, wipes it and places each held key anew.
// Throughput: one request at a time; the next is accepted in the cycle after the result loads.
// Reset: synchronous, active low; a clearing pass over every entry follows, in_tready low.
`default_nettype none
module coalesced_hash_set_engine
  import chs_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // key_type[3:0], key_value[67:4], key_hash[99:68], 0
  input  wire logic [1:0]   in_tuser,   // kind[1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata   // status[2:0], item_count[11:3], 0
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [AW:0] LEND = (AW+1)'(TABLE_SIZE);
  localparam logic [AW:0] LAST = (AW+1)'(TABLE_SIZE - 1);
  localparam int LOAD_LIM = TABLE_SIZE * LOAD_NUM;

  // table entry: used flag, chain link (LEND = end), key fields
  typedef struct packed {
    logic              used;
    logic [AW:0]       link;
    logic [TYPE_W-1:0] typ;
    logic [HASH_W-1:0] hash;
    logic [VALUE_W-1:0] key;
  } ent_t;

  // rebuild scratch entry
  typedef struct packed {
    logic              used;
    logic [TYPE_W-1:0] typ;
    logic [HASH_W-1:0] hash;
    logic [VALUE_W-1:0] key;
  } rbe_t;

  typedef enum logic [21:0] {
    S_CLR    = 22'h000001,
    S_IDLE   = 22'h000002,
    S_LCHK   = 22'h000004,
    S_PL_RD  = 22'h000008,
    S_PL_HD  = 22'h000010,
    S_TF_RD  = 22'h000020,
    S_TF_CHK = 22'h000040,
    S_PL_LNK = 22'h000080,
    S_W_CHK  = 22'h000100,
    S_W_P    = 22'h000200,
    S_W_M    = 22'h000400,
    S_PL_END = 22'h000800,
    S_CP     = 22'h001000,
    S_WIPE   = 22'h002000,
    S_RB_RD  = 22'h004000,
    S_RB_CHK = 22'h008000,
    S_RM_P   = 22'h010000,
    S_RM_W   = 22'h020000,
    S_RM_N   = 22'h040000,
    S_RM_X   = 22'h080000,
    S_DONE   = 22'h100000,
    S_SPARE  = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  // request fields
  kind_t              kind_r, kind_nxt;
  logic [TYPE_W-1:0]  ty_r, ty_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;

  // key under placement (request key or a key being rehomed)
  logic [TYPE_W-1:0]  pty_r, pty_nxt;
  logic [VALUE_W-1:0] pkey_r, pkey_nxt;
  logic [HASH_W-1:0]  phash_r, phash_nxt;

  // walk state
  logic [AW:0]   cur_r, cur_nxt;
  logic [AW:0]   prv_r, prv_nxt;
  logic [AW:0]   n_r, n_nxt;
  ent_t          cur_e_r, cur_e_nxt;
  ent_t          prv_e_r, prv_e_nxt;
  ent_t          hd_r, hd_nxt;
  logic [AW-1:0] m_r, m_nxt;
  logic [AW-1:0] f_r, f_nxt;

  logic [AW:0]   cursor_r, cursor_nxt;  // all ones = exhausted
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW:0]   idx_r, idx_nxt;        // clear, copy and rebuild index
  logic          rbmode_r, rbmode_nxt;
  logic          retried_r, retried_nxt;
  status_t       st_r, st_nxt;

  logic          ovalid_r, ovalid_nxt;
  status_t       ostat_r, ostat_nxt;
  logic [COUNT_W-1:0] ocnt_r, ocnt_nxt;

  // memory ports
  logic          t_wen, t_ren, r_wen, r_ren;
  logic [AW-1:0] t_waddr, t_raddr, r_waddr, r_raddr;
  ent_t          t_wdata, t_rq;
  rbe_t          r_wdata, r_rq;

  chs_ram #(.DEPTH(TABLE_SIZE), .WIDTH($bits(ent_t))) u_tbl (
    .clk  (clk),
    .wen  (t_wen),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .ren  (t_ren),
    .raddr(t_raddr),
    .rdata(t_rq)
  );

  chs_ram #(.DEPTH(TABLE_SIZE), .WIDTH($bits(rbe_t))) u_rb (
    .clk  (clk),
    .wen  (r_wen),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .ren  (r_ren),
    .raddr(r_raddr),
    .rdata(r_rq)
  );

  ent_t        wipe_e;
  logic        hit, pl_fail, in_acc;
  logic [31:0] cnt32, load32;
  logic [AW:0] om;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'd0, ocnt_r, ostat_r};

  always_comb begin
    wipe_e      = '0;
    wipe_e.link = LEND;
  end

  assign cnt32  = 32'(cnt_r);
  assign load32 = (cnt32 + 32'd1) * 32'(LOAD_DEN);
  assign hit    = t_rq.used && (t_rq.hash == hash_r) && (t_rq.typ == ty_r) &&
                  (t_rq.key == key_r);
  assign om     = {1'b0, hd_r.hash[AW-1:0]};

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    ty_nxt      = ty_r;
    key_nxt     = key_r;
    hash_nxt    = hash_r;
    pty_nxt     = pty_r;
    pkey_nxt    = pkey_r;
    phash_nxt   = phash_r;
    cur_nxt     = cur_r;
    prv_nxt     = prv_r;
    n_nxt       = n_r;
    cur_e_nxt   = cur_e_r;
    prv_e_nxt   = prv_e_r;
    hd_nxt      = hd_r;
    m_nxt       = m_r;
    f_nxt       = f_r;
    cursor_nxt  = cursor_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    rbmode_nxt  = rbmode_r;
    retried_nxt = retried_r;
    st_nxt      = st_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ostat_nxt   = ostat_r;
    ocnt_nxt    = ocnt_r;
    pl_fail     = 1'b0;

    t_wen   = 1'b0;
    t_waddr = '0;
    t_wdata = wipe_e;
    t_ren   = 1'b0;
    t_raddr = '0;
    r_wen   = 1'b0;
    r_waddr = '0;
    r_wdata = t_rq[$bits(rbe_t)-1:0] | {t_rq.used, {($bits(rbe_t)-1){1'b0}}};
    r_ren   = 1'b0;
    r_raddr = '0;

    unique case (state_r)
      S_CLR: begin
        t_wen   = 1'b1;
        t_waddr = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        t_ren   = 1'b1;
        t_raddr = in_tdata[68 +: AW];
        if (in_acc) begin
          kind_nxt = kind_t'(in_tuser);
          ty_nxt   = in_tdata[3:0];
          key_nxt  = in_tdata[67:4];
          hash_nxt = in_tdata[99:68];
          cur_nxt  = {1'b0, in_tdata[68 +: AW]};
          prv_nxt  = LEND;
          n_nxt    = '0;
          if (kind_t'(in_tuser) == KIND_NOP) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LCHK;
          end
        end
      end

      // chain walk: t_rq holds the entry at cur_r
      S_LCHK: begin
        if (hit) begin
          cur_e_nxt = t_rq;
          case (kind_r)
            KIND_FIND: begin
              st_nxt    = ST_FOUND;
              state_nxt = S_DONE;
            end
            KIND_REMOVE: begin
              if (prv_r != LEND) begin
                state_nxt = S_RM_P;
              end else if (t_rq.link >= LEND) begin
                state_nxt = S_RM_W;
              end else begin
                t_ren     = 1'b1;
                t_raddr   = t_rq.link[AW-1:0];
                state_nxt = S_RM_N;
              end
            end
            default: begin
              st_nxt    = ST_PRESENT;
              state_nxt = S_DONE;
            end
          endcase
        end else if (((n_r == '0) && !t_rq.used) || (t_rq.link >= LEND) ||
                     ((n_r + 1'b1) >= LEND)) begin
          case (kind_r)
            KIND_FIND: begin
              st_nxt    = ST_NOTFOUND;
              state_nxt = S_DONE;
            end
            KIND_REMOVE: begin
              st_nxt    = ST_RMISS;
              state_nxt = S_DONE;
            end
            default: begin
              if (load32 > 32'(LOAD_LIM)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                pty_nxt     = ty_r;
                pkey_nxt    = key_r;
                phash_nxt   = hash_r;
                rbmode_nxt  = 1'b0;
                retried_nxt = 1'b0;
                state_nxt   = S_PL_RD;
              end
            end
          endcase
        end else begin
          prv_nxt   = cur_r;
          prv_e_nxt = t_rq;
          cur_nxt   = t_rq.link;
          n_nxt     = n_r + 1'b1;
          t_ren     = 1'b1;
          t_raddr   = t_rq.link[AW-1:0];
        end
      end

      S_PL_RD: begin
        t_ren     = 1'b1;
        t_raddr   = phash_r[AW-1:0];
        m_nxt     = phash_r[AW-1:0];
        state_nxt = S_PL_HD;
      end

      S_PL_HD: begin
        hd_nxt = t_rq;
        if (!t_rq.used) begin
          t_wen     = 1'b1;
          t_waddr   = m_r;
          t_wdata   = '{used: 1'b1, link: LEND, typ: pty_r, hash: phash_r, key: pkey_r};
          state_nxt = S_PL_END;
        end else begin
          state_nxt = S_TF_RD;
        end
      end

      // descending free cursor
      S_TF_RD: begin
        if (cursor_r[AW]) begin
          pl_fail = 1'b1;
        end else begin
          t_ren      = 1'b1;
          t_raddr    = cursor_r[AW-1:0];
          f_nxt      = cursor_r[AW-1:0];
          cursor_nxt = cursor_r - 1'b1;
          state_nxt  = S_TF_CHK;
        end
      end

      S_TF_CHK: begin
        if (t_rq.used) begin
          state_nxt = S_TF_RD;
        end else if (om != {1'b0, m_r}) begin
          // home held by a foreign chain: find its predecessor
          t_ren     = 1'b1;
          t_raddr   = om[AW-1:0];
          cur_nxt   = om;
          n_nxt     = '0;
          state_nxt = S_W_CHK;
        end else begin
          t_wen     = 1'b1;
          t_waddr   = f_r;
          t_wdata   = '{used: 1'b1, link: hd_r.link, typ: pty_r, hash: phash_r,
                        key: pkey_r};
          state_nxt = S_PL_LNK;
        end
      end

      S_PL_LNK: begin
        t_wen     = 1'b1;
        t_waddr   = m_r;
        t_wdata   = hd_r;
        t_wdata.link = {1'b0, f_r};
        state_nxt = S_PL_END;
      end

      S_W_CHK: begin
        if (t_rq.link == {1'b0, m_r}) begin
          prv_e_nxt = t_rq;
          t_wen     = 1'b1;
          t_waddr   = f_r;
          t_wdata   = hd_r;
          t_wdata.used = 1'b1;
          state_nxt = S_W_P;
        end else if ((t_rq.link >= LEND) || ((n_r + 1'b1) >= LEND)) begin
          pl_fail = 1'b1;
        end else begin
          cur_nxt = t_rq.link;
          n_nxt   = n_r + 1'b1;
          t_ren   = 1'b1;
          t_raddr = t_rq.link[AW-1:0];
        end
      end

      S_W_P: begin
        t_wen        = 1'b1;
        t_waddr      = cur_r[AW-1:0];
        t_wdata      = prv_e_r;
        t_wdata.link = {1'b0, f_r};
        state_nxt    = S_W_M;
      end

      S_W_M: begin
        t_wen     = 1'b1;
        t_waddr   = m_r;
        t_wdata   = '{used: 1'b1, link: LEND, typ: pty_r, hash: phash_r, key: pkey_r};
        state_nxt = S_PL_END;
      end

      S_PL_END: begin
        if (rbmode_r) begin
          state_nxt = S_RB_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          st_nxt    = ST_INSERTED;
          state_nxt = S_DONE;
        end
      end

      // rebuild: copy table to scratch, one entry per cycle, pipelined
      S_CP: begin
        if (idx_r != '0) begin
          r_wen   = 1'b1;
          r_waddr = AW'(idx_r - 1'b1);
          r_wdata = '{used: t_rq.used, typ: t_rq.typ, hash: t_rq.hash, key: t_rq.key};
        end
        if (idx_r == LEND) begin
          idx_nxt   = '0;
          state_nxt = S_WIPE;
        end else begin
          t_ren   = 1'b1;
          t_raddr = idx_r[AW-1:0];
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_WIPE: begin
        t_wen   = 1'b1;
        t_waddr = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          idx_nxt    = '0;
          cursor_nxt = LAST;
          rbmode_nxt = 1'b1;
          state_nxt  = S_RB_RD;
        end
      end

      S_RB_RD: begin
        if (idx_r == LEND) begin
          rbmode_nxt  = 1'b0;
          retried_nxt = 1'b1;
          pty_nxt     = ty_r;
          pkey_nxt    = key_r;
          phash_nxt   = hash_r;
          state_nxt   = S_PL_RD;
        end else begin
          r_ren     = 1'b1;
          r_raddr   = idx_r[AW-1:0];
          state_nxt = S_RB_CHK;
        end
      end

      S_RB_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (r_rq.used) begin
          pty_nxt   = r_rq.typ;
          pkey_nxt  = r_rq.key;
          phash_nxt = r_rq.hash;
          state_nxt = S_PL_RD;
        end else begin
          state_nxt = S_RB_RD;
        end
      end

      // remove
      S_RM_P: begin
        t_wen        = 1'b1;
        t_waddr      = prv_r[AW-1:0];
        t_wdata      = prv_e_r;
        t_wdata.link = cur_e_r.link;
        state_nxt    = S_RM_W;
      end

      S_RM_W: begin
        t_wen   = 1'b1;
        t_waddr = cur_r[AW-1:0];
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        st_nxt    = ST_REMOVED;
        state_nxt = S_DONE;
      end

      S_RM_N: begin
        // successor moves into the home slot
        t_wen     = 1'b1;
        t_waddr   = cur_r[AW-1:0];
        t_wdata   = t_rq;
        state_nxt = S_RM_X;
      end

      S_RM_X: begin
        t_wen   = 1'b1;
        t_waddr = cur_e_r.link[AW-1:0];
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        st_nxt    = ST_REMOVED;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = st_r;
          ocnt_nxt   = cnt32[COUNT_W-1:0];
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // placement failed: rebuild once, otherwise refuse
    if (pl_fail) begin
      if (rbmode_r || retried_r) begin
        st_nxt    = ST_FULL;
        state_nxt = S_DONE;
      end else begin
        idx_nxt   = '0;
        state_nxt = S_CP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      idx_r     <= '0;
      cursor_r  <= LAST;
      cnt_r     <= '0;
      rbmode_r  <= 1'b0;
      retried_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cursor_r  <= cursor_nxt;
      cnt_r     <= cnt_nxt;
      rbmode_r  <= rbmode_nxt;
      retried_r <= retried_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    ty_r    <= ty_nxt;
    key_r   <= key_nxt;
    hash_r  <= hash_nxt;
    pty_r   <= pty_nxt;
    pkey_r  <= pkey_nxt;
    phash_r <= phash_nxt;
    cur_r   <= cur_nxt;
    prv_r   <= prv_nxt;
    n_r     <= n_nxt;
    cur_e_r <= cur_e_nxt;
    prv_e_r <= prv_e_nxt;
    hd_r    <= hd_nxt;
    m_r     <= m_nxt;
    f_r     <= f_nxt;
    st_r    <= st_nxt;
    ostat_r <= ostat_nxt;
    ocnt_r  <= ocnt_nxt;
  end

endmodule
`default_nettype wire
